// File: rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, switched off while reset is held
`define STQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent check on the rising clock edge that also holds during reset
`define STQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/stq_pkg.sv
// shared types and constants of the stack to queue transfer engine
package stq_pkg;

  // field widths of the stream payloads
  localparam int unsigned OP_W       = 3;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned STATUS_W   = 2;

  // packing of the slave side tdata: op in the lowest bits, then the word
  localparam int unsigned OP_LSB    = 0;
  localparam int unsigned DIN_LSB   = OP_LSB + OP_W;
  localparam int unsigned S_TDATA_W = ((DIN_LSB + IN_DATA_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_ENQ  = 3'd2,
    OP_DEQ  = 3'd3,
    OP_XFER = 3'd4,
    OP_DUMP = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_WAIT,
    S_DEQ_WAIT,
    S_XFER_RD,
    S_XFER_WR,
    S_DUMP
  } state_e;

endpackage

// File: rtl/stq_ram.sv
// generic single write port, single read port ram with registered read data
module stq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/stack_to_queue_transfer_engine_unit.sv
// top level of the stack to queue transfer engine
//
// One input transfer on the s_axis channel carries an operation code and a
// word: push, pop, enqueue, dequeue, transfer of the whole stack into the
// queue tail (order reversed), or dump of the queue from head to tail.
// Results leave on the m_axis channel: the word in tdata, the status
// (ok, empty, full) in tuser, and tlast on the final result of an item.
// Push and enqueue answer in the cycle after acceptance; pop and dequeue
// first read the word from a memory with registered read data, then pass it
// to the output register. Transfer moves one word at a time (stack read,
// then queue write) until the stack is empty or the queue is full and ends
// with one result. Dump reads the queue memory once per word and delivers
// one word per cycle while the receiver takes them. Op codes six and seven
// give no result. One item is worked on at a time; s_axis_tready_o is high
// only while the sequencer is idle and the output register can take a
// result.
// Reset clears the counts and the head pointer; the memories are not cleared
// and need no clearing pass. When the receiver stalls, the result waits in
// the output register and the sequencer holds until it is taken.
module stack_to_queue_transfer_engine_unit
  import stq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH  = 32,
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // op [2:0], data_in [34:3]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,  // data_out [31:0]
  output logic [STATUS_W-1:0]  m_axis_tuser_o,  // status [1:0]
  output logic                 m_axis_tlast_o
);

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  state_e state_q, state_d;
  logic [SCW-1:0] sc_q, sc_d;
  logic [QAW-1:0] qh_q, qh_d;
  logic [QCW-1:0] qc_q, qc_d;
  logic [QAW-1:0] dptr_q, dptr_d;
  logic [QCW-1:0] dleft_q, dleft_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;
  status_e               out_status_q;
  logic                  out_last_q;

  // memory ports
  logic                  st_we, st_re;
  logic [SAW-1:0]        st_waddr, st_raddr;
  logic [DATA_WIDTH-1:0] st_wdata, st_rdata;
  logic                  qu_we, qu_re;
  logic [QAW-1:0]        qu_waddr, qu_raddr;
  logic [DATA_WIDTH-1:0] qu_wdata, qu_rdata;

  // result from the sequencer
  logic                  emit;
  logic [DATA_WIDTH-1:0] emit_data;
  status_e               emit_status;
  logic                  emit_last;

  logic                  out_free;
  op_e                   in_op;
  logic [DATA_WIDTH-1:0] in_word;
  logic                  stack_full, stack_empty, queue_full, queue_empty;
  logic [QAW:0]          tail_sum;
  logic [QAW-1:0]        q_tail, qh_inc, dptr_inc;

  // input fields
  assign in_op   = op_e'(s_axis_tdata_i[OP_LSB +: OP_W]);
  assign in_word = DATA_WIDTH'(s_axis_tdata_i[DIN_LSB +: IN_DATA_W]);

  // store status
  assign stack_full  = (sc_q == SCW'(STACK_DEPTH));
  assign stack_empty = (sc_q == '0);
  assign queue_full  = (qc_q == QCW'(QUEUE_DEPTH));
  assign queue_empty = (qc_q == '0);

  // circular queue pointers
  assign tail_sum = (QAW+1)'(qh_q) + (QAW+1)'(qc_q);
  assign q_tail   = (tail_sum >= (QAW+1)'(QUEUE_DEPTH)) ?
                    QAW'(tail_sum - (QAW+1)'(QUEUE_DEPTH)) : QAW'(tail_sum);
  assign qh_inc   = (qh_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : qh_q + QAW'(1);
  assign dptr_inc = (dptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : dptr_q + QAW'(1);

  assign out_free = !out_valid_q || m_axis_tready_i;

  // sequencer: next state, memory accesses and results
  always_comb begin
    state_d         = state_q;
    sc_d            = sc_q;
    qh_d            = qh_q;
    qc_d            = qc_q;
    dptr_d          = dptr_q;
    dleft_d         = dleft_q;
    st_we           = 1'b0;
    st_waddr        = SAW'(sc_q);
    st_wdata        = in_word;
    st_re           = 1'b0;
    st_raddr        = SAW'(sc_q - SCW'(1));
    qu_we           = 1'b0;
    qu_waddr        = q_tail;
    qu_wdata        = in_word;
    qu_re           = 1'b0;
    qu_raddr        = qh_q;
    emit            = 1'b0;
    emit_data       = '0;
    emit_status     = ST_OK;
    emit_last       = 1'b1;
    s_axis_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = out_free;
        if (s_axis_tvalid_i && out_free) begin
          case (in_op)
            OP_PUSH: begin
              emit = 1'b1;
              if (stack_full) begin
                emit_status = ST_FULL;
              end else begin
                st_we = 1'b1;
                sc_d  = sc_q + SCW'(1);
              end
            end
            OP_POP: begin
              if (stack_empty) begin
                emit        = 1'b1;
                emit_data   = '1;
                emit_status = ST_EMPTY;
              end else begin
                st_re   = 1'b1;
                sc_d    = sc_q - SCW'(1);
                state_d = S_POP_WAIT;
              end
            end
            OP_ENQ: begin
              emit = 1'b1;
              if (queue_full) begin
                emit_status = ST_FULL;
              end else begin
                qu_we = 1'b1;
                qc_d  = qc_q + QCW'(1);
              end
            end
            OP_DEQ: begin
              if (queue_empty) begin
                emit        = 1'b1;
                emit_data   = '1;
                emit_status = ST_EMPTY;
              end else begin
                qu_re   = 1'b1;
                qh_d    = qh_inc;
                qc_d    = qc_q - QCW'(1);
                state_d = S_DEQ_WAIT;
              end
            end
            OP_XFER: begin
              state_d = S_XFER_RD;
            end
            OP_DUMP: begin
              if (queue_empty) begin
                emit        = 1'b1;
                emit_data   = '1;
                emit_status = ST_EMPTY;
              end else begin
                qu_re   = 1'b1;
                dptr_d  = qh_inc;
                dleft_d = qc_q;
                state_d = S_DUMP;
              end
            end
            default: begin
              // unused codes are dropped without a result
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = st_rdata;
          state_d   = S_IDLE;
        end
      end
      S_DEQ_WAIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = qu_rdata;
          state_d   = S_IDLE;
        end
      end
      S_XFER_RD: begin
        if (stack_empty) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else if (queue_full) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = ST_FULL;
            state_d     = S_IDLE;
          end
        end else begin
          st_re   = 1'b1;
          sc_d    = sc_q - SCW'(1);
          state_d = S_XFER_WR;
        end
      end
      S_XFER_WR: begin
        qu_we    = 1'b1;
        qu_wdata = st_rdata;
        qc_d     = qc_q + QCW'(1);
        state_d  = S_XFER_RD;
      end
      S_DUMP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = qu_rdata;
          emit_last = (dleft_q == QCW'(1));
          if (dleft_q == QCW'(1)) begin
            state_d = S_IDLE;
          end else begin
            qu_re    = 1'b1;
            qu_raddr = dptr_q;
            dptr_d   = dptr_inc;
            dleft_d  = dleft_q - QCW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sc_q        <= '0;
      qh_q        <= '0;
      qc_q        <= '0;
      dptr_q      <= '0;
      dleft_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sc_q        <= sc_d;
      qh_q        <= qh_d;
      qc_q        <= qc_d;
      dptr_q      <= dptr_d;
      dleft_q     <= dleft_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register
  assign out_valid_d = emit || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q   <= OUT_DATA_W'(emit_data);
      out_status_q <= emit_status;
      out_last_q   <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = M_TDATA_W'(out_data_q);
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  // stack memory
  stq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // queue memory
  stq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (qu_we),
    .waddr_i (qu_waddr),
    .wdata_i (qu_wdata),
    .re_i    (qu_re),
    .raddr_i (qu_raddr),
    .rdata_o (qu_rdata)
  );

endmodule

// File: rtl/stq_checker.sv
// port level checks of the stack to queue transfer engine, bound to the top level
`include "assert_macros.svh"

module stq_checker
  import stq_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid_i,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_i,
  input logic [STATUS_W-1:0]  m_axis_tuser_i,
  input logic                 m_axis_tlast_i
);

  property p_hold_stalled;
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i) &&
      $stable(m_axis_tlast_i);
  endproperty

  property p_empty_last;
    m_axis_tvalid_i && m_axis_tuser_i == ST_EMPTY |-> m_axis_tlast_i;
  endproperty

  property p_full_zero;
    m_axis_tvalid_i && m_axis_tuser_i == ST_FULL |-> m_axis_tlast_i && m_axis_tdata_i == '0;
  endproperty

  // a stalled result keeps its payload
  `STQ_ASSERT(a_hold_stalled, p_hold_stalled, "stalled result changed")

  // an empty status always closes its item
  `STQ_ASSERT(a_empty_last, p_empty_last, "empty status without last")

  // a full status closes its item and carries a zero word
  `STQ_ASSERT(a_full_zero, p_full_zero, "full status with data or without last")

  // no result is offered in the cycle after reset is seen
  `STQ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid_i, "result offered after reset")

endmodule

bind stack_to_queue_transfer_engine_unit stq_checker u_stq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
